### hdl/rsm_pkg.sv
package rsm_pkg;

  localparam int unsigned MAX_DISKS = 64;
  localparam int unsigned N_W       = 7;   // disk count register width
  localparam int unsigned DISK_W    = 6;   // disk index width on the outputs
  localparam int unsigned DVD_W     = 32;  // dividend and quotient width
  localparam int unsigned DVS_W     = 16;  // divisor and remainder width
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned IDX_W     = 2;

  typedef enum logic [2:0] {
    MODE_RAID0  = 3'd0,
    MODE_RAID1  = 3'd1,
    MODE_RAID01 = 3'd2,
    MODE_RAID10 = 3'd3,
    MODE_RAID4  = 3'd4,
    MODE_RAID5  = 3'd5,
    MODE_RES6   = 3'd6,
    MODE_RES7   = 3'd7
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RAID_MODE     = 2'd0,
    REG_DISK_COUNT    = 2'd1,
    REG_CHUNK_SECTORS = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  // Side-band data that travels alongside an item through a divider.
  typedef struct packed {
    mode_t              mode;
    logic [DVS_W-1:0]   rem1;
    logic [DVD_W-1:0]   quo1;
  } tag_t;

endpackage

### hdl/rsm_div.sv
module rsm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rsm_pkg::DVD_W-1:0]  dividend,
  input  logic [rsm_pkg::DVS_W-1:0]  divisor,
  input  rsm_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output logic [rsm_pkg::DVD_W-1:0]  quotient,
  output logic [rsm_pkg::DVS_W-1:0]  remainder,
  output rsm_pkg::tag_t              out_tag
);

  localparam int unsigned S = rsm_pkg::DVD_W;

  // One quotient bit per stage. The work word shifts left: dividend bits leave
  // at the top while quotient bits enter at the bottom.
  logic                       vld  [S+1];
  logic [rsm_pkg::DVD_W-1:0]  work [S+1];
  logic [rsm_pkg::DVS_W-1:0]  rem  [S+1];
  logic [rsm_pkg::DVS_W-1:0]  dvs  [S+1];
  rsm_pkg::tag_t              tag  [S+1];

  assign vld[0]  = in_valid;
  assign work[0] = dividend;
  assign rem[0]  = '0;
  assign dvs[0]  = divisor;
  assign tag[0]  = in_tag;

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [rsm_pkg::DVS_W:0] shifted;
    logic [rsm_pkg::DVS_W:0] diff;
    logic                    take;

    always_comb begin
      shifted = {rem[s], work[s][rsm_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, dvs[s]};
      take    = (shifted >= {1'b0, dvs[s]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        work[s+1] <= {work[s][rsm_pkg::DVD_W-2:0], take};
        rem[s+1]  <= take ? diff[rsm_pkg::DVS_W-1:0] : shifted[rsm_pkg::DVS_W-1:0];
        dvs[s+1]  <= dvs[s];
        tag[s+1]  <= tag[s];
      end
    end
  end

  assign out_valid = vld[S];
  assign quotient  = work[S];
  assign remainder = rem[S];
  assign out_tag   = tag[S];

endmodule

### hdl/raid_sector_mapper_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  logical_sector (32)
// result    out        out_valid/out_stall  data_disk, disk_sector, extra_disk, extra_valid
// config    in         cfg_we               cfg_index, cfg_data
//
// One item is accepted per cycle unless a stalled result holds the pipeline.
// Each item passes through two 32-stage pipelined dividers in series, one
// quotient bit per stage, and then through the output register.
// Synchronous reset empties the pipeline and loads the register defaults.
// A stalled result freezes the whole pipeline, so in_stall follows it.
module raid_sector_mapper_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       logical_sector,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsm_pkg::DISK_W-1:0]        data_disk,
  output logic [31:0]                       disk_sector,
  output logic [rsm_pkg::DISK_W-1:0]        extra_disk,
  output logic                              extra_valid,
  input  logic                              cfg_we,
  input  logic [rsm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rsm_pkg::CFG_W-1:0]         cfg_data
);

  logic [2:0]                 raid_mode;
  logic [rsm_pkg::N_W-1:0]    disk_count;
  logic [15:0]                chunk_sectors;

  always_ff @(posedge clk) begin
    if (rst) begin
      raid_mode     <= 3'd0;
      disk_count    <= rsm_pkg::N_W'(2);
      chunk_sectors <= 16'd1;
    end else if (cfg_we) begin
      unique case (rsm_pkg::reg_idx_t'(cfg_index))
        rsm_pkg::REG_RAID_MODE:     raid_mode     <= cfg_data[2:0];
        rsm_pkg::REG_DISK_COUNT:    disk_count    <= cfg_data[rsm_pkg::N_W-1:0];
        rsm_pkg::REG_CHUNK_SECTORS: chunk_sectors <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sanitised configuration.
  logic [rsm_pkg::N_W-1:0] n;
  logic [rsm_pkg::N_W-1:0] half;
  logic [rsm_pkg::N_W-1:0] nm1;
  logic [15:0]             c;
  rsm_pkg::mode_t          mode;

  always_comb begin
    if (disk_count < rsm_pkg::N_W'(2)) begin
      n = rsm_pkg::N_W'(2);
    end else if (disk_count > rsm_pkg::N_W'(rsm_pkg::MAX_DISKS)) begin
      n = rsm_pkg::N_W'(rsm_pkg::MAX_DISKS);
    end else begin
      n = disk_count;
    end
    half = n >> 1;
    nm1  = n - rsm_pkg::N_W'(1);
    c    = (chunk_sectors == 16'd0) ? 16'd1 : chunk_sectors;
    case (rsm_pkg::mode_t'(raid_mode)) inside
      rsm_pkg::MODE_RES6, rsm_pkg::MODE_RES7: mode = rsm_pkg::MODE_RAID5;
      default:                                mode = rsm_pkg::mode_t'(raid_mode);
    endcase
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // First division: by chunk size, half the disks, one or disks less one.
  logic [15:0]   div1_dvs;
  rsm_pkg::tag_t div1_tag;

  always_comb begin
    case (mode)
      rsm_pkg::MODE_RAID0:                         div1_dvs = c;
      rsm_pkg::MODE_RAID01, rsm_pkg::MODE_RAID10:  div1_dvs = 16'(half);
      rsm_pkg::MODE_RAID1:                         div1_dvs = 16'd1;
      default:                                     div1_dvs = 16'(nm1);
    endcase
    div1_tag      = '0;
    div1_tag.mode = mode;
  end

  logic          d1_valid;
  logic [31:0]   d1_quo;
  logic [15:0]   d1_rem;
  rsm_pkg::tag_t d1_tag;

  rsm_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  (logical_sector),
    .divisor   (div1_dvs),
    .in_tag    (div1_tag),
    .out_valid (d1_valid),
    .quotient  (d1_quo),
    .remainder (d1_rem),
    .out_tag   (d1_tag)
  );

  // Second division: the first quotient by the disk count.
  rsm_pkg::tag_t div2_tag;
  always_comb begin
    div2_tag      = d1_tag;
    div2_tag.rem1 = d1_rem;
    div2_tag.quo1 = d1_quo;
  end

  logic          d2_valid;
  logic [31:0]   d2_quo;
  logic [15:0]   d2_rem;
  rsm_pkg::tag_t d2_tag;

  rsm_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .dividend  (d1_quo),
    .divisor   (16'(n)),
    .in_tag    (div2_tag),
    .out_valid (d2_valid),
    .quotient  (d2_quo),
    .remainder (d2_rem),
    .out_tag   (d2_tag)
  );

  // Final mapping per level.
  logic [rsm_pkg::DISK_W-1:0] disk_next;
  logic [31:0]                sector_next;
  logic [rsm_pkg::DISK_W-1:0] extra_next;
  logic                       evalid_next;
  logic [47:0]                prod;
  logic [7:0]                 r1n;
  logic [7:0]                 parity;
  logic [7:0]                 sum5;
  logic [7:0]                 tmp;

  always_comb begin
    prod   = d2_quo * c;
    r1n    = d2_tag.rem1[7:0];
    parity = 8'(nm1) - d2_rem[7:0];
    sum5   = r1n + parity + 8'd1;
    if (sum5 >= 8'(n)) begin
      sum5 = sum5 - 8'(n);
    end
    tmp         = '0;
    disk_next   = '0;
    sector_next = d2_tag.quo1;
    extra_next  = '0;
    evalid_next = 1'b1;
    case (d2_tag.mode)
      rsm_pkg::MODE_RAID0: begin
        disk_next   = d2_rem[rsm_pkg::DISK_W-1:0];
        sector_next = prod[31:0] + {16'd0, d2_tag.rem1};
        evalid_next = 1'b0;
      end
      rsm_pkg::MODE_RAID1: begin
        extra_next = rsm_pkg::DISK_W'(1);
      end
      rsm_pkg::MODE_RAID01: begin
        disk_next  = r1n[rsm_pkg::DISK_W-1:0];
        tmp        = r1n + 8'(half);
        extra_next = tmp[rsm_pkg::DISK_W-1:0];
      end
      rsm_pkg::MODE_RAID10: begin
        tmp        = r1n << 1;
        disk_next  = tmp[rsm_pkg::DISK_W-1:0];
        extra_next = tmp[rsm_pkg::DISK_W-1:0] + rsm_pkg::DISK_W'(1);
      end
      rsm_pkg::MODE_RAID4: begin
        disk_next  = r1n[rsm_pkg::DISK_W-1:0];
        extra_next = nm1[rsm_pkg::DISK_W-1:0];
      end
      default: begin
        disk_next  = sum5[rsm_pkg::DISK_W-1:0];
        extra_next = parity[rsm_pkg::DISK_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_valid;
    end
    if (en) begin
      data_disk   <= disk_next;
      disk_sector <= sector_next;
      extra_disk  <= extra_next;
      extra_valid <= evalid_next;
    end
  end

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid && !extra_valid |-> extra_disk == '0)
    else $error("extra disk set without extra_valid");

  a_disk_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, data_disk} < n)
    else $error("data disk beyond disk count");

  a_extra_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && extra_valid |-> {1'b0, extra_disk} < n)
    else $error("extra disk beyond disk count");

endmodule

### test/raid_sector_mapper_unit_tb.sv
`timescale 1ns / 1ps

module raid_sector_mapper_unit_tb;

  typedef struct {
    logic [rsm_pkg::DISK_W-1:0] data_disk;
    logic [31:0]                disk_sector;
    logic [rsm_pkg::DISK_W-1:0] extra_disk;
    logic                       extra_valid;
  } location_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [31:0]                  logical_sector = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rsm_pkg::DISK_W-1:0]   data_disk;
  logic [31:0]                  disk_sector;
  logic [rsm_pkg::DISK_W-1:0]   extra_disk;
  logic                         extra_valid;
  logic                         cfg_we = 1'b0;
  logic [rsm_pkg::IDX_W-1:0]    cfg_index = rsm_pkg::REG_RAID_MODE;
  logic [rsm_pkg::CFG_W-1:0]    cfg_data = '0;

  // Shadow copy of the array settings.
  rsm_pkg::mode_t               array_mode;
  logic [rsm_pkg::N_W-1:0]      array_disks;
  logic [15:0]                  array_chunk;

  location_t           pending_locations[$];
  int unsigned         error_count = 0;
  int unsigned         sender_idle_pct = 0;
  int unsigned         receiver_idle_pct = 0;
  int unsigned         hold_off_cycles = 0;
  bit                  hold_off_request = 1'b0;

  raid_sector_mapper_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .logical_sector (logical_sector),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_disk      (data_disk),
    .disk_sector    (disk_sector),
    .extra_disk     (extra_disk),
    .extra_valid    (extra_valid),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic location_t map_sector(logic [31:0] sector_in);
    longint unsigned q, n, c, half, chunk, stripe, parity;
    longint unsigned disk, sector, extra;
    location_t loc;
    q = sector_in;
    n = array_disks;
    c = array_chunk;
    disk = 0;
    sector = 0;
    extra = 0;
    if (n < 2) n = 2;
    if (n > rsm_pkg::MAX_DISKS) n = rsm_pkg::MAX_DISKS;
    if (c == 0) c = 1;
    half = n / 2;
    loc.extra_valid = 1'b1;
    case (array_mode)
      rsm_pkg::MODE_RAID0: begin
        chunk = q / c;
        disk = chunk % n;
        sector = (chunk / n) * c + q % c;
        loc.extra_valid = 1'b0;
      end
      rsm_pkg::MODE_RAID1: begin
        sector = q;
        extra = 1;
      end
      rsm_pkg::MODE_RAID01: begin
        disk = q % half;
        sector = q / half;
        extra = disk + half;
      end
      rsm_pkg::MODE_RAID10: begin
        disk = (q % half) * 2;
        sector = q / half;
        extra = disk + 1;
      end
      rsm_pkg::MODE_RAID4: begin
        disk = q % (n - 1);
        sector = q / (n - 1);
        extra = n - 1;
      end
      default: begin
        // Left-symmetric parity rotation; the reserved modes behave likewise.
        stripe = q / (n - 1);
        parity = n - 1 - stripe % n;
        disk = (q % (n - 1) + parity + 1) % n;
        sector = stripe;
        extra = parity;
      end
    endcase
    loc.data_disk = disk[rsm_pkg::DISK_W-1:0];
    loc.disk_sector = sector[31:0];
    loc.extra_disk = extra[rsm_pkg::DISK_W-1:0];
    return loc;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Receiver stall, with an occasional long hold-off counted here.
  always @(posedge clk) begin
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_off_cycles = 400;
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    location_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_locations.size() == 0) begin
        report_mismatch("result with no item pending", disk_sector, 0);
      end else begin
        want = pending_locations.pop_front();
        if (data_disk !== want.data_disk)
          report_mismatch("data_disk", data_disk, want.data_disk);
        if (disk_sector !== want.disk_sector)
          report_mismatch("disk_sector", disk_sector, want.disk_sector);
        if (extra_disk !== want.extra_disk)
          report_mismatch("extra_disk", extra_disk, want.extra_disk);
        if (extra_valid !== want.extra_valid)
          report_mismatch("extra_valid", extra_valid, want.extra_valid);
      end
    end
  end

  task automatic send_item(logic [31:0] sector_in);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    logical_sector <= sector_in;
    do @(posedge clk); while (in_stall);
    pending_locations.push_back(map_sector(sector_in));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_locations.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(rsm_pkg::reg_idx_t idx, logic [rsm_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsm_pkg::REG_RAID_MODE:     array_mode = rsm_pkg::mode_t'(value[2:0]);
      rsm_pkg::REG_DISK_COUNT:    array_disks = value[rsm_pkg::N_W-1:0];
      rsm_pkg::REG_CHUNK_SECTORS: array_chunk = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(rsm_pkg::mode_t mode, logic [rsm_pkg::N_W-1:0] disks,
                           logic [15:0] chunk);
    drain();
    write_reg(rsm_pkg::REG_RAID_MODE, rsm_pkg::CFG_W'(mode));
    write_reg(rsm_pkg::REG_DISK_COUNT, rsm_pkg::CFG_W'(disks));
    write_reg(rsm_pkg::REG_CHUNK_SECTORS, chunk);
  endtask

  task automatic test_reset_defaults;
    send_item(32'd0);
    send_item(32'd5);
    send_item(32'hFFFF_FFFF);
  endtask

  task automatic test_directed;
    rsm_pkg::mode_t m;
    // Every mode, including the reserved ones, at the edge sector values.
    for (int i = 0; i < 8; i++) begin
      m = rsm_pkg::mode_t'(i);
      configure(m, (i % 2) ? 7'd64 : 7'd3, 16'd1);
      send_item(32'hFFFF_FFFF);
      send_item(32'd1);
    end
    // Disk counts outside the range are clamped; a zero chunk acts as one.
    configure(rsm_pkg::MODE_RAID0, 7'd0, 16'd0);
    send_item(32'h8000_0001);
    configure(rsm_pkg::MODE_RAID5, 7'd1, 16'hFFFF);
    send_item(32'h7FFF_FFFF);
    configure(rsm_pkg::MODE_RAID0, 7'd127, 16'hFFFF);
    send_item(32'hFFFF_FFFF);
    send_item(32'h0001_2345);
    configure(rsm_pkg::MODE_RAID10, 7'd65, 16'd1);
    send_item(32'hFFFF_FFFE);
    drain();
    write_reg(rsm_pkg::REG_NONE, 16'hFFFF);
    send_item(32'd63);
  endtask

  task automatic random_config;
    logic [rsm_pkg::N_W-1:0] disks;
    logic [15:0] chunk;
    case ($urandom_range(3))
      0: disks = rsm_pkg::N_W'($urandom_range(127));
      1: disks = ($urandom_range(1)) ? 7'd2 : 7'd64;
      default: disks = rsm_pkg::N_W'($urandom_range(64, 2));
    endcase
    case ($urandom_range(3))
      0: chunk = 16'($urandom_range(65535));
      1: chunk = ($urandom_range(1)) ? 16'd1 : 16'hFFFF;
      default: chunk = 16'($urandom_range(16, 1));
    endcase
    configure(rsm_pkg::mode_t'($urandom_range(7)), disks, chunk);
  endtask

  task automatic test_random_phases(int unsigned send_pct, int unsigned recv_pct);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    for (int p = 0; p < 7; p++) begin
      random_config();
      for (int i = 0; i < 45; i++)
        send_item(($urandom_range(3) == 0) ? 32'($urandom_range(4095)) : $urandom);
    end
  endtask

  task automatic test_backpressure;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    random_config();
    hold_off_request = 1'b1;
    for (int i = 0; i < 120; i++)
      send_item($urandom);
  endtask

  initial begin
    in_valid <= 1'b0;
    array_mode = rsm_pkg::MODE_RAID0;
    array_disks = 7'd2;
    array_chunk = 16'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phases(31, 84);
    test_random_phases(84, 31);
    test_random_phases(0, 0);
    test_backpressure();
    drain();
    repeat (70) @(posedge clk);
    if (error_count == 0)
      $display("raid_sector_mapper_unit_tb: done, clean");
    else
      $display("raid_sector_mapper_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("raid_sector_mapper_unit_tb: done, errors");
    $finish;
  end

endmodule
